FILE: design/tbr_pkg.sv
// ----------------------------------------------------------------------------
// tbr_pkg
// Shared types and constants for the TFTP block receiver.
// ----------------------------------------------------------------------------
package tbr_pkg;

    localparam int DEF_DISK_BLOCK_BYTES   = 512;
    localparam int DEF_BUFFER_DISK_BLOCKS = 32;
    localparam int DATA_BLOCK_BYTES       = 512;

    localparam logic [15:0] OP_DATA   = 16'd3;
    localparam logic [15:0] OP_ERROR  = 16'd5;
    localparam logic [15:0] HDR_BYTES = 16'd4;
    localparam logic [15:0] MAX_PACKET_BYTES = 16'(DATA_BLOCK_BYTES) + HDR_BYTES;

    localparam logic CMD_PACKET  = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_DONE    = 3'd1,
        ST_PEER    = 3'd2,
        ST_SEQ     = 3'd3,
        ST_TIMEOUT = 3'd4
    } t_status;

endpackage

FILE: design/tftp_block_receiver.sv
// ----------------------------------------------------------------------------
// tftp_block_receiver
// Receive-side decision logic of a TFTP transfer, one packet header or
// timeout event per word, one result word per input word.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : i_in_valid / o_in_ready with i_cmd, i_opcode,
//                    i_block_number, i_packet_length
//   result channel : o_out_valid / i_out_ready with ack, timeout error,
//                    staging-buffer append and flush fields and status
//   config channel : i_cfg_valid / o_cfg_ready with i_cfg_server_mode,
//                    always ready, write only while the block is idle
//   Each accepted word is decided in the cycle it is accepted and its result
//   is shown in the next cycle from the output register.
//   One word per cycle is sustained: a new word is taken in the same cycle
//   the held result is taken. A stalled result register holds its word and
//   o_in_ready stays low until the result is taken.
//   Reset clears the block counter, the buffered byte count, the phase
//   (running) and server mode (client). Once the phase leaves running every
//   later word gives an all-zero result carrying the final status.
// ----------------------------------------------------------------------------
module tftp_block_receiver #(
    parameter int DISK_BLOCK_BYTES   = tbr_pkg::DEF_DISK_BLOCK_BYTES,
    parameter int BUFFER_DISK_BLOCKS = tbr_pkg::DEF_BUFFER_DISK_BLOCKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_server_mode,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [15:0] i_opcode,
    input  logic [15:0] i_block_number,
    input  logic [15:0] i_packet_length,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_send_ack,
    output logic [15:0] o_ack_block,
    output logic        o_send_timeout_error,
    output logic        o_append_valid,
    output logic [13:0] o_append_offset,
    output logic [9:0]  o_append_length,
    output logic [5:0]  o_flush_blocks,
    output logic [2:0]  o_status
);

    localparam logic [31:0] BUF_CAP = 32'(DISK_BLOCK_BYTES * BUFFER_DISK_BLOCKS);
    localparam longint unsigned RECIP =
        ((64'd1 << 32) + 64'(DISK_BLOCK_BYTES) - 64'd1) / 64'(DISK_BLOCK_BYTES);
    localparam logic [31:0] RECIP_32 = 32'(RECIP);
    localparam logic [15:0] ROUND_ADD = 16'(DISK_BLOCK_BYTES - 1);

    logic            r_server_mode;
    logic [15:0]     r_last_block;
    logic [14:0]     r_buffered;
    tbr_pkg::t_status r_phase;

    logic [15:0]     n_last_block;
    logic [14:0]     n_buffered;
    tbr_pkg::t_status n_phase;

    logic            r_out_valid;
    logic            r_send_ack;
    logic [15:0]     r_ack_block;
    logic            r_send_terr;
    logic            r_append_valid;
    logic [13:0]     r_append_offset;
    logic [9:0]      r_append_length;
    logic [5:0]      r_flush_blocks;
    logic [2:0]      r_status;

    logic            n_send_ack;
    logic [15:0]     n_ack_block;
    logic            n_send_terr;
    logic            n_append_valid;
    logic [13:0]     n_append_offset;
    logic [9:0]      n_append_length;
    logic [5:0]      n_flush_blocks;

    logic            w_in_accept;
    logic [15:0]     w_blk_next;
    logic [9:0]      w_alen;
    logic            w_has_payload;
    logic            w_fin;
    logic [14:0]     w_buf_after;
    logic [15:0]     w_round;
    logic [47:0]     w_prod;
    logic [5:0]      w_fin_blocks;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_accept = i_in_valid && o_in_ready;

    // payload placement and flush arithmetic
    assign w_blk_next    = r_last_block + 16'd1;
    assign w_alen        = 10'(i_packet_length - tbr_pkg::HDR_BYTES);
    assign w_has_payload = i_packet_length > tbr_pkg::HDR_BYTES;
    assign w_fin         = i_packet_length < tbr_pkg::MAX_PACKET_BYTES;
    assign w_buf_after   = w_has_payload ? (r_buffered + 15'(w_alen)) : r_buffered;
    assign w_round       = {1'b0, w_buf_after} + ROUND_ADD;
    assign w_prod        = 48'(w_round) * 48'(RECIP_32);
    assign w_fin_blocks  = w_prod[37:32];

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (r_phase == tbr_pkg::ST_RUN) begin
            if (i_cmd == tbr_pkg::CMD_TIMEOUT) begin
                if (!r_server_mode) begin
                    n_phase = tbr_pkg::ST_TIMEOUT;
                end
            end else if (i_opcode == tbr_pkg::OP_ERROR) begin
                n_phase = tbr_pkg::ST_PEER;
            end else if (i_opcode == tbr_pkg::OP_DATA) begin
                if (i_block_number != w_blk_next) begin
                    if (i_block_number != r_last_block && r_last_block == 16'd0) begin
                        n_phase = tbr_pkg::ST_SEQ;
                    end
                end else if (i_packet_length <= tbr_pkg::MAX_PACKET_BYTES && w_fin) begin
                    n_phase = tbr_pkg::ST_DONE;
                end
            end
        end
    end

    // result fields and counters
    always_comb begin
        n_last_block    = r_last_block;
        n_buffered      = r_buffered;
        n_send_ack      = 1'b0;
        n_ack_block     = '0;
        n_send_terr     = 1'b0;
        n_append_valid  = 1'b0;
        n_append_offset = '0;
        n_append_length = '0;
        n_flush_blocks  = '0;
        if (r_phase == tbr_pkg::ST_RUN) begin
            if (i_cmd == tbr_pkg::CMD_TIMEOUT) begin
                if (r_server_mode) begin
                    n_send_terr = 1'b1;
                end
            end else if (i_opcode == tbr_pkg::OP_DATA) begin
                if (i_block_number != w_blk_next) begin
                    if (i_block_number == r_last_block) begin
                        n_send_ack  = 1'b1;
                        n_ack_block = r_last_block;
                    end
                end else if (i_packet_length <= tbr_pkg::MAX_PACKET_BYTES) begin
                    n_last_block = w_blk_next;
                    n_send_ack   = 1'b1;
                    n_ack_block  = w_blk_next;
                    n_buffered   = w_buf_after;
                    if (w_has_payload) begin
                        n_append_valid  = 1'b1;
                        n_append_offset = r_buffered[13:0];
                        n_append_length = w_alen;
                    end
                    if (w_fin) begin
                        n_flush_blocks = w_fin_blocks;
                        n_buffered     = '0;
                    end else if (32'(w_buf_after) >= BUF_CAP) begin
                        n_flush_blocks = 6'(BUFFER_DISK_BLOCKS);
                        n_buffered     = w_buf_after - 15'(BUF_CAP);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_mode <= 1'b0;
            r_last_block  <= '0;
            r_buffered    <= '0;
            r_phase       <= tbr_pkg::ST_RUN;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_server_mode <= i_cfg_server_mode;
            end
            if (w_in_accept) begin
                r_last_block <= n_last_block;
                r_buffered   <= n_buffered;
                r_phase      <= n_phase;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_send_ack      <= n_send_ack;
            r_ack_block     <= n_ack_block;
            r_send_terr     <= n_send_terr;
            r_append_valid  <= n_append_valid;
            r_append_offset <= n_append_offset;
            r_append_length <= n_append_length;
            r_flush_blocks  <= n_flush_blocks;
            r_status        <= n_phase;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_send_ack           = r_send_ack;
    assign o_ack_block          = r_ack_block;
    assign o_send_timeout_error = r_send_terr;
    assign o_append_valid       = r_append_valid;
    assign o_append_offset      = r_append_offset;
    assign o_append_length      = r_append_length;
    assign o_flush_blocks       = r_flush_blocks;
    assign o_status             = r_status;

    // a terminal phase never changes
    a_phase_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != tbr_pkg::ST_RUN) |=> (r_phase == $past(r_phase)))
        else $error("phase left a terminal state");

    // a finished transfer leaves nothing buffered
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tbr_pkg::ST_DONE) |-> (r_buffered == 15'd0))
        else $error("buffer not empty after finish");

    // an append always comes with an acknowledgement and no timeout error
    a_append_acked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_append_valid) |-> (o_send_ack && !o_send_timeout_error))
        else $error("append without ack");

    // result status follows the stored phase
    a_status_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept) |=> (o_status == r_phase))
        else $error("status differs from phase");

    // payload length bounded by one data block
    a_append_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_append_valid) |->
        (o_append_length != 10'd0 && 32'(o_append_length) <= 32'(tbr_pkg::DATA_BLOCK_BYTES)))
        else $error("append length out of range");

endmodule

FILE: tb/sv/tb_tftp_block_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tftp_block_receiver
// Self-checking bench for the TFTP block receiver. Packet headers and
// timeouts are pushed through the input handshake with random gaps while the
// result side stalls at random. Every accepted word is run through an
// in-bench copy of the receive decision logic, and each result word is
// compared field by field against the oldest predicted decision. One
// randomly chosen way of ending the transfer is exercised, followed by
// words that must be ignored.
// ----------------------------------------------------------------------------
module tb_tftp_block_receiver;

    localparam int DISK_BYTES = tbr_pkg::DEF_DISK_BLOCK_BYTES;
    localparam int BUF_BLOCKS = tbr_pkg::DEF_BUFFER_DISK_BLOCKS;
    localparam int BUF_CAP    = DISK_BYTES * BUF_BLOCKS;
    localparam int SEG_WORDS  = 250;

    typedef struct packed {
        logic        cmd;
        logic [15:0] opcode;
        logic [15:0] block_number;
        logic [15:0] packet_length;
    } t_rx_word;

    typedef struct packed {
        logic        send_ack;
        logic [15:0] ack_block;
        logic        send_timeout_error;
        logic        append_valid;
        logic [13:0] append_offset;
        logic [9:0]  append_length;
        logic [5:0]  flush_blocks;
        logic [2:0]  status;
    } t_rx_decision;

    typedef enum int {
        END_SHORT,
        END_HEADER,
        END_PEER,
        END_TIMEOUT
    } t_end_kind;

    class rx_scoreboard;
        bit               server_mode;
        logic [15:0]      last_blk;
        logic [14:0]      buf_bytes;
        tbr_pkg::t_status phase;
        t_rx_decision     pending_decisions[$];
        int               mismatches;
        int               words_seen;
        int               results_seen;
        int               flushes_seen;

        function new();
            server_mode  = 1'b0;
            last_blk     = '0;
            buf_bytes    = '0;
            phase        = tbr_pkg::ST_RUN;
            mismatches   = 0;
            words_seen   = 0;
            results_seen = 0;
            flushes_seen = 0;
        endfunction

        function void set_mode(bit m);
            server_mode = m;
        endfunction

        // receive decision for one header or timeout, updates transfer state
        function t_rx_decision decide(t_rx_word w);
            t_rx_decision d;
            logic [15:0]  nxt;
            logic         fin;
            int           alen;
            d   = '0;
            nxt = last_blk + 16'd1;
            if (phase == tbr_pkg::ST_RUN) begin
                if (w.cmd == tbr_pkg::CMD_TIMEOUT) begin
                    if (server_mode)
                        d.send_timeout_error = 1'b1;
                    else
                        phase = tbr_pkg::ST_TIMEOUT;
                end else if (w.opcode == tbr_pkg::OP_ERROR) begin
                    phase = tbr_pkg::ST_PEER;
                end else if (w.opcode == tbr_pkg::OP_DATA) begin
                    if (w.block_number != nxt) begin
                        if (w.block_number == last_blk) begin
                            d.send_ack  = 1'b1;
                            d.ack_block = last_blk;
                        end else if (last_blk == 16'd0) begin
                            phase = tbr_pkg::ST_SEQ;
                        end
                    end else if (w.packet_length <= tbr_pkg::MAX_PACKET_BYTES) begin
                        fin         = w.packet_length < tbr_pkg::MAX_PACKET_BYTES;
                        last_blk    = nxt;
                        d.send_ack  = 1'b1;
                        d.ack_block = nxt;
                        if (w.packet_length > tbr_pkg::HDR_BYTES) begin
                            alen = int'(w.packet_length) - int'(tbr_pkg::HDR_BYTES);
                            d.append_valid  = 1'b1;
                            d.append_offset = buf_bytes[13:0];
                            d.append_length = alen[9:0];
                            buf_bytes       = 15'(int'(buf_bytes) + alen);
                        end
                        if (fin) begin
                            d.flush_blocks = 6'((int'(buf_bytes) + DISK_BYTES - 1) / DISK_BYTES);
                            buf_bytes      = '0;
                            phase          = tbr_pkg::ST_DONE;
                        end else if (int'(buf_bytes) >= BUF_CAP) begin
                            d.flush_blocks = 6'(BUF_BLOCKS);
                            buf_bytes      = 15'(int'(buf_bytes) - BUF_CAP);
                        end
                    end
                end
            end
            d.status = phase;
            return d;
        endfunction

        function void note_input(t_rx_word w);
            pending_decisions.push_back(decide(w));
            words_seen++;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                          results_seen, name, got, want));
        endtask

        task check_result(t_rx_decision got);
            t_rx_decision want;
            if (pending_decisions.size() == 0) begin
                report_mismatch("result word with no input word waiting");
                return;
            end
            want = pending_decisions.pop_front();
            results_seen++;
            if (got.flush_blocks != 0)
                flushes_seen++;
            check_field("send_ack", 16'(got.send_ack), 16'(want.send_ack));
            check_field("ack_block", got.ack_block, want.ack_block);
            check_field("send_timeout_error", 16'(got.send_timeout_error),
                        16'(want.send_timeout_error));
            check_field("append_valid", 16'(got.append_valid), 16'(want.append_valid));
            check_field("append_offset", 16'(got.append_offset), 16'(want.append_offset));
            check_field("append_length", 16'(got.append_length), 16'(want.append_length));
            check_field("flush_blocks", 16'(got.flush_blocks), 16'(want.flush_blocks));
            check_field("status", 16'(got.status), 16'(want.status));
        endtask
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_server_mode = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_ready;
    t_rx_word     in_word = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    t_rx_decision out_word;

    bit           src_idle_on = 1'b0;
    bit           sink_idle_on = 1'b0;
    int           sink_hold = 0;
    t_end_kind    end_kind;
    rx_scoreboard sb;

    tftp_block_receiver dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_server_mode    (cfg_server_mode),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_cmd                (in_word.cmd),
        .i_opcode             (in_word.opcode),
        .i_block_number       (in_word.block_number),
        .i_packet_length      (in_word.packet_length),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_send_ack           (out_word.send_ack),
        .o_ack_block          (out_word.ack_block),
        .o_send_timeout_error (out_word.send_timeout_error),
        .o_append_valid       (out_word.append_valid),
        .o_append_offset      (out_word.append_offset),
        .o_append_length      (out_word.append_length),
        .o_flush_blocks       (out_word.flush_blocks),
        .o_status             (out_word.status)
    );

    always #2 clk = ~clk;

    // result side stalls
    always @(posedge clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            out_ready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
            sink_hold = $urandom_range(0, 8);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_word);
    end

    function automatic int idle_gap();
        if (src_idle_on && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 9);
        return 0;
    endfunction

    task automatic send_word(t_rx_word w);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_input(w);
    endtask

    task automatic send(logic c, logic [15:0] op, logic [15:0] blk, logic [15:0] len);
        t_rx_word w;
        w.cmd           = c;
        w.opcode        = op;
        w.block_number  = blk;
        w.packet_length = len;
        send_word(w);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_decisions.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_mode(bit m);
        cfg_valid       <= 1'b1;
        cfg_server_mode <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_mode(m);
    endtask

    // mostly in-sequence full blocks, plus repeats, oversize, noise, timeouts
    function automatic t_rx_word random_word(bit allow_timeout);
        t_rx_word    w;
        logic [15:0] nxt;
        int          pick;
        nxt             = sb.last_blk + 16'd1;
        w.cmd           = tbr_pkg::CMD_PACKET;
        w.opcode        = tbr_pkg::OP_DATA;
        w.block_number  = nxt;
        w.packet_length = tbr_pkg::MAX_PACKET_BYTES;
        pick            = $urandom_range(0, 99);
        if (pick >= 92 && allow_timeout) begin
            w.cmd           = tbr_pkg::CMD_TIMEOUT;
            w.opcode        = 16'($urandom);
            w.block_number  = 16'($urandom);
            w.packet_length = 16'($urandom);
        end else if (pick >= 84 && sb.last_blk != 16'd0) begin
            do w.block_number = 16'($urandom);
            while (w.block_number == nxt || w.block_number == sb.last_blk);
            w.packet_length = 16'($urandom);
        end else if (pick >= 76) begin
            do w.opcode = 16'($urandom);
            while (w.opcode == tbr_pkg::OP_DATA || w.opcode == tbr_pkg::OP_ERROR);
            w.block_number  = 16'($urandom);
            w.packet_length = 16'($urandom);
        end else if (pick >= 70) begin
            w.packet_length =
                16'($urandom_range(int'(tbr_pkg::MAX_PACKET_BYTES) + 1, 65535));
        end else if (pick >= 62) begin
            w.block_number  = sb.last_blk;
            w.packet_length = 16'($urandom);
        end
        return w;
    endfunction

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored opcodes, repeats, oversize, wrong blocks, timeouts
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send(tbr_pkg::CMD_PACKET, 16'h0000, 16'h0000, 16'h0000);
        send(tbr_pkg::CMD_PACKET, 16'hffff, 16'hffff, 16'hffff);
        send(tbr_pkg::CMD_PACKET, 16'd4, 16'd1, tbr_pkg::MAX_PACKET_BYTES);
        send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, 16'd0, tbr_pkg::MAX_PACKET_BYTES);
        send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, 16'd1,
             tbr_pkg::MAX_PACKET_BYTES + 16'd1);
        send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, 16'd1, 16'hffff);
        send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, 16'd1, tbr_pkg::MAX_PACKET_BYTES);
        send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, 16'd1, 16'd0);
        send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, 16'd3, tbr_pkg::MAX_PACKET_BYTES);
        send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, 16'd0, tbr_pkg::MAX_PACKET_BYTES);
        send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, 16'hffff, 16'hffff);
        send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, 16'd2, tbr_pkg::MAX_PACKET_BYTES);
        settle();
        write_mode(1'b1);
        send(tbr_pkg::CMD_TIMEOUT, tbr_pkg::OP_ERROR, 16'hffff, 16'hffff);
        send(tbr_pkg::CMD_TIMEOUT, 16'h0000, 16'h0000, 16'h0000);
        send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, 16'd3, tbr_pkg::MAX_PACKET_BYTES);
        send(tbr_pkg::CMD_PACKET, 16'd2, 16'd3, 16'd4);

        // random segments, alternating client and server mode
        for (int seg = 0; seg < 8; seg++) begin
            settle();
            write_mode(seg % 2 == 0);
            src_idle_on  = $urandom_range(0, 1);
            sink_idle_on = $urandom_range(0, 1);
            repeat (SEG_WORDS) send_word(random_word(sb.server_mode));
        end

        // end of the transfer, no idling from here on
        settle();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        write_mode(1'b1);
        send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, 16'd0, 16'($urandom));
        send(tbr_pkg::CMD_TIMEOUT, 16'($urandom), 16'($urandom), 16'($urandom));
        end_kind = t_end_kind'($urandom_range(0, 3));
        case (end_kind)
            END_SHORT: begin
                send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, sb.last_blk + 16'd1,
                     16'($urandom_range(5, 515)));
            end
            END_HEADER: begin
                send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_DATA, sb.last_blk + 16'd1,
                     16'($urandom_range(0, 4)));
            end
            END_PEER: begin
                send(tbr_pkg::CMD_PACKET, tbr_pkg::OP_ERROR, 16'($urandom), 16'($urandom));
            end
            default: begin
                settle();
                write_mode(1'b0);
                send(tbr_pkg::CMD_TIMEOUT, 16'($urandom), 16'($urandom), 16'($urandom));
            end
        endcase
        repeat (20) begin
            send(1'($urandom_range(0, 1)), 16'($urandom_range(0, 5)),
                 16'($urandom_range(0, 2)), 16'($urandom));
        end
        settle();
        repeat (4) @(posedge clk);

        $display("run covered %0d words and %0d result words, %0d buffer flushes",
                 sb.words_seen, sb.results_seen, sb.flushes_seen);
        $display("transfer ended by %s with status %s",
                 end_kind.name(), sb.phase.name());
        if (sb.mismatches == 0 && sb.pending_decisions.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
